### sv/wildcard_pattern_matcher_macros.svh
// Assertion macros shared by the wildcard pattern matcher.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef WILDCARD_PATTERN_MATCHER_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPM_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wildcard_pattern_matcher: implication check failed");

// The expression must never be true outside reset.
`define WPM_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("wildcard_pattern_matcher: forbidden condition seen");

`endif

### sv/wpm_pkg.sv
// Types and constants shared by the wildcard pattern matcher modules.
// No dependencies.
package wpm_pkg;

  localparam int CMD_W     = 2;
  localparam int SYM_W     = 5;
  localparam int START_W   = 32;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LETTER = 2'd2;

  localparam logic [SYM_W-1:0] WILDCARD_CODE = 5'd26;

  localparam int QUEUE_DEPTH = 2;
  localparam int QCOUNT_W    = 2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_LETTER
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] sym;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic fire;
    op_t  op;
    logic result_load;
  } back_status_t;

endpackage

### sv/wpm_front.sv
// Front end: accepts input beats and classifies the command into an operation.
// Depends on wpm_pkg; feeds wpm_queue.
module wpm_front (
  input  logic                       in_valid,
  input  logic [wpm_pkg::CMD_W-1:0]  command,
  input  logic [wpm_pkg::SYM_W-1:0]  symbol,
  input  wpm_pkg::queue_status_t     q_status,
  output logic                       in_stall,
  output wpm_pkg::push_t             push
);
  import wpm_pkg::*;

  logic accept;
  logic known;
  op_t  op;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  always_comb begin
    known = 1'b1;
    op    = OP_CLEAR;
    unique case (command)
      CMD_CLEAR:  op = OP_CLEAR;
      CMD_APPEND: op = OP_APPEND;
      CMD_LETTER: op = OP_LETTER;
      default:    known = 1'b0;
    endcase
  end

  // Unknown commands are consumed here and never reach the back end.
  always_comb begin
    push.valid    = accept && known;
    push.item.op  = op;
    push.item.sym = symbol;
  end

endmodule

### sv/wpm_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on wpm_pkg.
module wpm_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  wpm_pkg::push_t         push,
  input  logic                   pop,
  output wpm_pkg::queue_status_t q_status,
  output wpm_pkg::item_t         head
);
  import wpm_pkg::*;

  item_t               entries [QUEUE_DEPTH];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [QCOUNT_W-1:0] count;
  logic [QCOUNT_W-1:0] count_next;

  assign q_status.full  = (count == QCOUNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign head           = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push.valid && !pop) begin
      count_next = count + QCOUNT_W'(1);
    end else if (!push.valid && pop) begin
      count_next = count - QCOUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.item;
    end
  end

endmodule

### sv/wpm_back.sv
// Back end: holds pattern and match vector; runs one operation per cycle unless stalled.
// Depends on wpm_pkg; drains wpm_queue and drives the output register.
module wpm_back #(
  parameter int PATTERN_MAX   = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wpm_pkg::item_t               head,
  input  wpm_pkg::queue_status_t       q_status,
  input  logic                         out_stall,
  output logic                         pop,
  output logic                         out_valid,
  output logic [wpm_pkg::START_W-1:0]  match_start,
  output wpm_pkg::back_status_t        b_status
);
  import wpm_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int SUB_W = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;
  localparam logic [POSITION_BITS-1:0] POSITION_TOP = '1;

  logic [SYM_W-1:0]         pattern_store [PATTERN_MAX];
  logic [LEN_W-1:0]         pattern_length;
  logic                     has_letter;
  logic [PATTERN_MAX-1:0]   len_mask;      // positions below pattern_length
  logic [PATTERN_MAX-1:0]   last_hot;      // one-hot on the last pattern position
  logic [PATTERN_MAX-1:0]   match_vector;
  logic [POSITION_BITS-1:0] text_position;

  logic                     fire;
  logic                     do_clear;
  logic                     do_append;
  logic                     do_letter;
  logic [PATTERN_MAX-1:0]   append_hot;
  logic [PATTERN_MAX-1:0]   letter_mask;
  logic [PATTERN_MAX-1:0]   match_vector_next;
  logic                     hit;
  logic [SUB_W-1:0]         start_diff;
  logic [SUB_W+START_W-1:0] start_ext;

  assign fire      = !q_status.empty && !(out_valid && out_stall);
  assign pop       = fire;
  assign do_clear  = fire && (head.op == OP_CLEAR);
  assign do_append = fire && (head.op == OP_APPEND) && !len_mask[PATTERN_MAX-1];
  assign do_letter = fire && (head.op == OP_LETTER) && (text_position != POSITION_TOP);

  // Next free pattern position as a one-hot vector.
  assign append_hot = ~len_mask & ((len_mask << 1) | PATTERN_MAX'(1));

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      letter_mask[i] = len_mask[i] &&
                       (pattern_store[i] >= WILDCARD_CODE || pattern_store[i] == head.sym);
    end
  end

  assign match_vector_next = ((match_vector << 1) | PATTERN_MAX'(1)) & letter_mask;
  assign hit = has_letter && (|(match_vector_next & last_hot));

  // Start index is text_position - (pattern_length - 1); a hit implies it is not negative.
  assign start_diff = SUB_W'(text_position) - SUB_W'(pattern_length) + SUB_W'(1);
  assign start_ext  = {{START_W{1'b0}}, start_diff};

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      has_letter     <= 1'b0;
      len_mask       <= '0;
      last_hot       <= '0;
      match_vector   <= '0;
      text_position  <= '0;
    end else if (do_clear) begin
      pattern_length <= '0;
      has_letter     <= 1'b0;
      len_mask       <= '0;
      last_hot       <= '0;
      match_vector   <= '0;
      text_position  <= '0;
    end else if (do_append) begin
      pattern_length <= pattern_length + LEN_W'(1);
      len_mask       <= len_mask | append_hot;
      last_hot       <= append_hot;
      if (head.sym < WILDCARD_CODE) begin
        has_letter <= 1'b1;
      end
    end else if (do_letter) begin
      match_vector  <= match_vector_next;
      text_position <= text_position + POSITION_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (do_append && append_hot[i]) begin
        pattern_store[i] <= head.sym;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= do_letter && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (do_letter && hit) begin
      match_start <= start_ext[START_W-1:0];
    end
  end

  always_comb begin
    b_status.fire        = fire;
    b_status.op          = head.op;
    b_status.result_load = do_letter && hit;
  end

endmodule

### sv/wildcard_pattern_matcher.sv
// Wildcard pattern matcher (shift-and): finds every start index of a pattern in a text stream.
// Usage:
//   Input channel: command and symbol qualified by in_valid; a beat is taken when in_valid
//   is high and in_stall is low. Command 0 clears the pattern and text index, 1 appends a
//   pattern symbol (26 or above is a wildcard), 2 presents a text letter, 3 is dropped.
//   Output channel: match_start qualified by out_valid; a beat is taken when out_valid is high
//   and out_stall is low. Each letter completing a not-all-wildcard pattern sends one beat.
//   Throughput: one input beat per cycle unless out_stall holds a waiting result, set by the
//   shift-and update over all pattern positions at once in the back end. A two-entry queue sits
//   between the decode front end and the back end, so a new beat is taken while a result waits
//   in the output register. An accepted letter passes through the queue to the output register.
//   Stall: while out_stall holds a waiting result, the back end stops and the queue fills;
//   in_stall then rises and the held result stays unchanged.
//   Reset: rst (synchronous) empties the pattern, the match vector, the text index and the
//   queue. Pattern symbol storage is not cleared; only written positions are ever used.
//   The text index saturates at its top value, after which letters give no result.
module wildcard_pattern_matcher #(
  parameter int PATTERN_MAX   = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [wpm_pkg::CMD_W-1:0]    command,
  input  logic [wpm_pkg::SYM_W-1:0]    symbol,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [wpm_pkg::START_W-1:0]  match_start
);
  import wpm_pkg::*;

  push_t         push;
  queue_status_t q_status;
  item_t         head;
  logic          pop;
  back_status_t  b_status;

  wpm_front u_front (
    .in_valid (in_valid),
    .command  (command),
    .symbol   (symbol),
    .q_status (q_status),
    .in_stall (in_stall),
    .push     (push)
  );

  wpm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .q_status (q_status),
    .head     (head)
  );

  wpm_back #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .out_stall   (out_stall),
    .pop         (pop),
    .out_valid   (out_valid),
    .match_start (match_start),
    .b_status    (b_status)
  );

`include "wildcard_pattern_matcher_macros.svh"

  `WPM_ASSERT_IMPLIES(a_result_from_letter, b_status.result_load, b_status.fire && b_status.op == OP_LETTER)
  `WPM_ASSERT_IMPLIES(a_pop_needs_data, b_status.fire, !q_status.empty)
  `WPM_ASSERT_NEVER(a_queue_status_sane, q_status.full && q_status.empty)
  `WPM_ASSERT_IMPLIES(a_push_has_room, push.valid, !q_status.full)

endmodule
